>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the flow cache RTL.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NFC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/nfc_pkg.sv
// Shared types, codes and constants of the flow cache.
// Used by nfc_cell, nfc_uptime and netflow_flow_cache_unit.
package nfc_pkg;

    localparam int CACHE_ENTRIES_DEF = 32;

    localparam int MS_PER_S = 1000;
    localparam int US_PER_S = 1000000;
    localparam int US_MAX   = US_PER_S - 1;

    // Reciprocal of 1000 scaled by 2^30, exact for values below one million.
    localparam int DIV_MUL   = 1073742;
    localparam int DIV_SHIFT = 30;

    localparam logic [15:0] INACT_S_RST = 16'd10;
    localparam logic [15:0] ACT_S_RST   = 16'd60;
    localparam logic [5:0]  LIMIT_RST   = 6'd32;

    localparam logic [1:0] CFG_INACTIVE = 2'd0;
    localparam logic [1:0] CFG_ACTIVE   = 2'd1;
    localparam logic [1:0] CFG_LIMIT    = 2'd2;

    typedef struct packed {
        logic        valid;
        logic        mark;
        logic [63:0] addr;
        logic [39:0] ppr;
        logic [7:0]  tos;
        logic [5:0]  flags;
        logic [31:0] pk;
        logic [31:0] oc;
        logic [31:0] fi;
        logic [31:0] la;
    } t_entry;

    typedef enum logic [2:0] {
        C_HOLD,
        C_FROM_LEFT,
        C_FROM_RIGHT,
        C_LOAD,
        C_HIT,
        C_MARK
    } t_cell_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TIME0,
        S_TIME1,
        S_PASS1,
        S_LOOK,
        S_COUNT,
        S_EVICT,
        S_INSERT,
        S_PASS2,
        S_DRAIN
    } t_state;

endpackage

>>> hw/rtl/netflow_flow_cache_unit.sv
// Flow cache top level: control sequencer around a sorted chain of entry cells.
// Depends on nfc_pkg, nfc_cell, nfc_uptime and assert_macros.svh.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  packet   | i_valid / o_ready          | five-tuple, tos, flags, length, time
//  export   | o_valid / i_ready          | one flow record, last_of_run
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A request passes the uptime pipeline (TIME0, TIME1), the first timeout pass and the
// lookup. A miss then counts the occupancy, evicts the oldest live entry while the count
// is at the limit or over, and inserts. Both then take the second timeout pass and walk
// the cells held through the chain, exporting the marked ones.
// A stalled export holds the walk; a new request is taken once the walk ends.
// Synchronous reset clears cells, sequencer and o_valid and sets the config defaults.
`include "assert_macros.svh"

module netflow_flow_cache_unit #(
    parameter int CACHE_ENTRIES = nfc_pkg::CACHE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_destination_address,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_destination_port,
    input  logic [7:0]  i_protocol,
    input  logic [7:0]  i_type_of_service,
    input  logic [5:0]  i_tcp_flags,
    input  logic [15:0] i_byte_length,
    input  logic [31:0] i_time_seconds,
    input  logic [19:0] i_time_microseconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_out_source_address,
    output logic [31:0] o_out_destination_address,
    output logic [15:0] o_out_source_port,
    output logic [15:0] o_out_destination_port,
    output logic [7:0]  o_out_protocol,
    output logic [7:0]  o_out_type_of_service,
    output logic [5:0]  o_out_tcp_flags,
    output logic [31:0] o_packet_count,
    output logic [31:0] o_octet_count,
    output logic [31:0] o_first_ms,
    output logic [31:0] o_last_ms,
    output logic        o_last_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int NCELL = CACHE_ENTRIES + 1;
    localparam int CW    = $clog2(NCELL + 1);

    nfc_pkg::t_state   r_state;
    nfc_pkg::t_state   n_state;
    logic [25:0]       r_inact_ms;
    logic [25:0]       r_act_ms;
    logic [5:0]        r_limit;
    logic [63:0]       r_addr;
    logic [39:0]       r_ppr;
    logic [7:0]        r_tos;
    logic [5:0]        r_flags;
    logic [15:0]       r_len;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     n_cnt;
    logic [CW-1:0]     r_fill;
    logic [CW-1:0]     n_fill;
    logic [CW-1:0]     r_rem;
    logic [CW-1:0]     n_rem;
    logic [31:0]       w_now;
    logic [5:0]        w_lim;
    logic              w_accept;
    nfc_pkg::t_entry   w_pkt;
    nfc_pkg::t_entry   w_new;
    nfc_pkg::t_entry   w_head;
    nfc_pkg::t_entry   w_none;
    nfc_pkg::t_entry   w_ent   [NCELL];
    nfc_pkg::t_entry   w_left  [NCELL];
    nfc_pkg::t_entry   w_right [NCELL];
    nfc_pkg::t_cell_op w_op    [NCELL];
    logic [NCELL-1:0]  w_exp;
    logic [NCELL-1:0]  w_match;
    logic [NCELL-1:0]  w_after;
    logic [NCELL-1:0]  w_valid;
    logic [NCELL-1:0]  w_mark;
    logic [NCELL-1:0]  w_live;
    logic [NCELL-1:0]  w_ev_oh;
    logic [NCELL-1:0]  w_ins_oh;
    logic [NCELL-1:0]  w_below;
    logic [NCELL-1:0]  w_xmark;
    logic              w_head_exp;
    logic              w_step;
    logic              w_out_load;
    logic              w_evict;
    logic              r_o_valid;
    nfc_pkg::t_entry   r_out;
    logic              r_last;

    assign w_accept = i_valid && o_ready;
    assign o_ready  = (r_state == nfc_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inact_ms <= 26'(nfc_pkg::INACT_S_RST) * 26'(nfc_pkg::MS_PER_S);
            r_act_ms   <= 26'(nfc_pkg::ACT_S_RST) * 26'(nfc_pkg::MS_PER_S);
            r_limit    <= nfc_pkg::LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nfc_pkg::CFG_INACTIVE: begin
                    r_inact_ms <= 26'(i_cfg_data) * 26'(nfc_pkg::MS_PER_S);
                end
                nfc_pkg::CFG_ACTIVE: begin
                    r_act_ms <= 26'(i_cfg_data) * 26'(nfc_pkg::MS_PER_S);
                end
                nfc_pkg::CFG_LIMIT: begin
                    r_limit <= i_cfg_data[5:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_limit == 6'd0) begin
            w_lim = 6'd1;
        end else if (7'(r_limit) > 7'(CACHE_ENTRIES)) begin
            w_lim = 6'(CACHE_ENTRIES);
        end else begin
            w_lim = r_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr  <= {i_source_address, i_destination_address};
            r_ppr   <= {i_source_port, i_destination_port, i_protocol};
            r_tos   <= i_type_of_service;
            r_flags <= i_tcp_flags;
            r_len   <= i_byte_length;
        end
    end

    nfc_uptime u_uptime (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_sec   (i_time_seconds),
        .i_usec  (i_time_microseconds),
        .o_now   (w_now)
    );

    always_comb begin
        w_pkt       = '0;
        w_pkt.valid = 1'b1;
        w_pkt.addr  = r_addr;
        w_pkt.ppr   = r_ppr;
        w_pkt.tos   = r_tos;
        w_pkt.flags = r_flags;
        w_pkt.pk    = 32'd1;
        w_pkt.oc    = 32'(r_len);
        w_pkt.fi    = w_now;
        w_pkt.la    = w_now;
        w_none      = '0;
        w_head      = w_ent[0];
        w_head.mark = 1'b0;
    end

    assign w_new = (r_state == nfc_pkg::S_DRAIN) ? w_head : w_pkt;

    genvar g;
    generate
        for (g = 0; g < NCELL; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_left[g] = w_none;
            end else begin : g_mid
                assign w_left[g] = w_ent[g-1];
            end
            if (g == NCELL - 1) begin : g_last
                assign w_right[g] = w_none;
            end else begin : g_inner
                assign w_right[g] = w_ent[g+1];
            end

            nfc_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_op       (w_op[g]),
                .i_left     (w_left[g]),
                .i_right    (w_right[g]),
                .i_new      (w_new),
                .i_now      (w_now),
                .i_inact_ms (r_inact_ms),
                .i_act_ms   (r_act_ms),
                .o_ent      (w_ent[g]),
                .o_expire   (w_exp[g]),
                .o_match    (w_match[g]),
                .o_after    (w_after[g])
            );

            assign w_valid[g] = w_ent[g].valid;
            assign w_mark[g]  = w_ent[g].mark;
        end
    endgenerate

    assign w_live     = w_valid & ~w_mark;
    assign w_xmark    = w_valid & w_mark;
    assign w_ev_oh    = w_live & (~w_live + NCELL'(1));
    assign w_ins_oh   = w_after & (~w_after + NCELL'(1));
    assign w_below    = w_ins_oh - NCELL'(1);
    assign w_head_exp = w_xmark[0];
    assign w_step     = !w_head_exp || !r_o_valid || i_ready;
    assign w_out_load = (r_state == nfc_pkg::S_DRAIN) && w_head_exp && w_step;
    assign w_evict    = (7'(r_cnt) >= 7'(w_lim));

    always_comb begin
        n_state = r_state;
        case (r_state)
            nfc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = nfc_pkg::S_TIME0;
                end
            end
            nfc_pkg::S_TIME0: begin
                n_state = nfc_pkg::S_TIME1;
            end
            nfc_pkg::S_TIME1: begin
                n_state = nfc_pkg::S_PASS1;
            end
            nfc_pkg::S_PASS1: begin
                n_state = nfc_pkg::S_LOOK;
            end
            nfc_pkg::S_LOOK: begin
                n_state = (|w_match) ? nfc_pkg::S_PASS2 : nfc_pkg::S_COUNT;
            end
            nfc_pkg::S_COUNT: begin
                n_state = nfc_pkg::S_EVICT;
            end
            nfc_pkg::S_EVICT: begin
                if (!w_evict) begin
                    n_state = nfc_pkg::S_INSERT;
                end
            end
            nfc_pkg::S_INSERT: begin
                n_state = nfc_pkg::S_PASS2;
            end
            nfc_pkg::S_PASS2: begin
                n_state = (r_fill == '0) ? nfc_pkg::S_IDLE : nfc_pkg::S_DRAIN;
            end
            nfc_pkg::S_DRAIN: begin
                if (w_step && (r_rem == CW'(1))) begin
                    n_state = nfc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nfc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_fill = r_fill;
        n_rem  = r_rem;
        for (int i = 0; i < NCELL; i++) begin
            w_op[i] = nfc_pkg::C_HOLD;
        end
        case (r_state)
            nfc_pkg::S_PASS1, nfc_pkg::S_PASS2: begin
                for (int i = 0; i < NCELL; i++) begin
                    w_op[i] = w_exp[i] ? nfc_pkg::C_MARK : nfc_pkg::C_HOLD;
                end
                n_rem = r_fill;
            end
            nfc_pkg::S_LOOK: begin
                for (int i = 0; i < NCELL; i++) begin
                    w_op[i] = w_match[i] ? nfc_pkg::C_HIT : nfc_pkg::C_HOLD;
                end
            end
            nfc_pkg::S_COUNT: begin
                n_cnt = r_fill - CW'($countones(w_xmark));
            end
            nfc_pkg::S_EVICT: begin
                if (w_evict) begin
                    for (int i = 0; i < NCELL; i++) begin
                        w_op[i] = w_ev_oh[i] ? nfc_pkg::C_MARK : nfc_pkg::C_HOLD;
                    end
                    n_cnt = r_cnt - CW'(1);
                end
            end
            nfc_pkg::S_INSERT: begin
                for (int i = 0; i < NCELL; i++) begin
                    if (w_ins_oh[i]) begin
                        w_op[i] = nfc_pkg::C_LOAD;
                    end else if (!w_below[i]) begin
                        w_op[i] = nfc_pkg::C_FROM_LEFT;
                    end
                end
                n_fill = r_fill + CW'(1);
            end
            nfc_pkg::S_DRAIN: begin
                if (w_step) begin
                    for (int i = 0; i < NCELL; i++) begin
                        if (!w_head_exp && (CW'(i) == r_fill - CW'(1))) begin
                            w_op[i] = nfc_pkg::C_LOAD;
                        end else begin
                            w_op[i] = nfc_pkg::C_FROM_RIGHT;
                        end
                    end
                    n_rem = r_rem - CW'(1);
                    if (w_head_exp) begin
                        n_fill = r_fill - CW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= nfc_pkg::S_IDLE;
            r_fill    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        if (w_out_load) begin
            r_out  <= w_ent[0];
            r_last <= ~|(w_xmark >> 1);
        end
    end

    assign o_valid                   = r_o_valid;
    assign o_out_source_address      = r_out.addr[63:32];
    assign o_out_destination_address = r_out.addr[31:0];
    assign o_out_source_port         = r_out.ppr[39:24];
    assign o_out_destination_port    = r_out.ppr[23:8];
    assign o_out_protocol            = r_out.ppr[7:0];
    assign o_out_type_of_service     = r_out.tos;
    assign o_out_tcp_flags           = r_out.flags;
    assign o_packet_count            = r_out.pk;
    assign o_octet_count             = r_out.oc;
    assign o_first_ms                = r_out.fi;
    assign o_last_ms                 = r_out.la;
    assign o_last_of_run             = r_last;

    `NFC_ASSERT_IMPLY(a_prefix, 1'b1, ((w_valid & (w_valid + NCELL'(1))) == '0), "cells not packed")
    `NFC_ASSERT_IMPLY(a_fill, (r_state == nfc_pkg::S_IDLE), (7'(r_fill) <= 7'(CACHE_ENTRIES)), "fill over capacity")
    `NFC_ASSERT_IMPLY(a_slot, (r_state == nfc_pkg::S_INSERT), (!w_valid[NCELL-1]), "no free cell on insert")
    `NFC_ASSERT_NEXT(a_clean, (r_state == nfc_pkg::S_DRAIN) && (n_state == nfc_pkg::S_IDLE), (w_xmark == '0), "marks left after walk")

endmodule

>>> hw/rtl/nfc_cell.sv
// One flow entry of the sorted cache chain, with its timeout and key compares.
// Depends on nfc_pkg.
module nfc_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nfc_pkg::t_cell_op i_op,
    input  nfc_pkg::t_entry   i_left,
    input  nfc_pkg::t_entry   i_right,
    input  nfc_pkg::t_entry   i_new,
    input  logic [31:0]       i_now,
    input  logic [25:0]       i_inact_ms,
    input  logic [25:0]       i_act_ms,
    output nfc_pkg::t_entry   o_ent,
    output logic              o_expire,
    output logic              o_match,
    output logic              o_after
);

    nfc_pkg::t_entry r_ent;
    nfc_pkg::t_entry n_ent;
    logic            r_valid;
    logic            r_mark;
    logic [31:0]     w_idle;
    logic [31:0]     w_span;

    always_comb begin
        o_ent       = r_ent;
        o_ent.valid = r_valid;
        o_ent.mark  = r_mark;
    end

    assign w_idle   = i_now - r_ent.la;
    assign w_span   = r_ent.la - r_ent.fi;
    assign o_expire = r_valid && ((w_idle > 32'(i_inact_ms)) || (w_span > 32'(i_act_ms))
                      || r_ent.flags[0] || r_ent.flags[2]);
    assign o_match  = r_valid && !r_mark && (r_ent.addr == i_new.addr)
                      && (r_ent.ppr == i_new.ppr);
    assign o_after  = !r_valid || ({i_new.fi, i_new.addr, i_new.ppr}
                      < {r_ent.fi, r_ent.addr, r_ent.ppr});

    always_comb begin
        n_ent = o_ent;
        case (i_op)
            nfc_pkg::C_HOLD: begin
                n_ent = o_ent;
            end
            nfc_pkg::C_FROM_LEFT: begin
                n_ent = i_left;
            end
            nfc_pkg::C_FROM_RIGHT: begin
                n_ent = i_right;
            end
            nfc_pkg::C_LOAD: begin
                n_ent = i_new;
            end
            nfc_pkg::C_HIT: begin
                n_ent.la    = i_now;
                n_ent.pk    = r_ent.pk + 32'd1;
                n_ent.oc    = r_ent.oc + i_new.oc;
                n_ent.flags = r_ent.flags | i_new.flags;
            end
            nfc_pkg::C_MARK: begin
                n_ent.mark = 1'b1;
            end
            default: begin
                n_ent = o_ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mark  <= 1'b0;
        end else begin
            r_valid <= n_ent.valid;
            r_mark  <= n_ent.valid && n_ent.mark;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

>>> hw/rtl/nfc_uptime.sv
// Uptime in milliseconds since the first packet, three register stages.
// Depends on nfc_pkg.
module nfc_uptime (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [31:0] i_sec,
    input  logic [19:0] i_usec,
    output logic [31:0] o_now
);

    logic               r_started;
    logic [31:0]        r_start_s;
    logic [19:0]        r_start_us;
    logic [31:0]        r_ds;
    logic [19:0]        r_du;
    logic [31:0]        r_ms;
    logic [9:0]         r_q;
    logic [31:0]        r_now;
    logic [19:0]        w_us;
    logic signed [20:0] w_du;
    logic [31:0]        n_ds;
    logic [19:0]        n_du;
    logic [40:0]        w_prod;

    assign w_us = (i_usec > 20'(nfc_pkg::US_MAX)) ? 20'(nfc_pkg::US_MAX) : i_usec;

    always_comb begin
        w_du = $signed({1'b0, w_us}) - $signed({1'b0, r_start_us});
        n_ds = i_sec - r_start_s;
        if (w_du < 0) begin
            w_du = w_du + 21'(nfc_pkg::US_PER_S);
            n_ds = n_ds - 32'd1;
        end
        n_du = w_du[19:0];
        if (!r_started) begin
            n_ds = '0;
            n_du = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
        end else if (i_load) begin
            r_started <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && !r_started) begin
            r_start_s  <= i_sec;
            r_start_us <= w_us;
        end
        if (i_load) begin
            r_ds <= n_ds;
            r_du <= n_du;
        end
    end

    assign w_prod = 41'(r_du) * 41'(nfc_pkg::DIV_MUL);

    always_ff @(posedge i_clk) begin
        r_ms  <= r_ds * 32'(nfc_pkg::MS_PER_S);
        r_q   <= w_prod[nfc_pkg::DIV_SHIFT +: 10];
        r_now <= r_ms + 32'(r_q);
    end

    assign o_now = r_now;

endmodule

>>> tb/sv/tb_netflow_flow_cache_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the flow cache: drives packets and register writes,
// predicts exported flow records in a scoreboard class and checks every record.
// Depends on nfc_pkg and netflow_flow_cache_unit.
module tb_netflow_flow_cache_unit;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int SLOTS = 32;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        bit [31:0] sa;
        bit [31:0] da;
        bit [15:0] sp;
        bit [15:0] dp;
        bit [7:0]  proto;
        bit [7:0]  tos;
        bit [5:0]  flags;
        bit [15:0] len;
        bit [31:0] ts;
        bit [19:0] tus;
    } t_packet;

    typedef struct {
        bit [63:0] addr;
        bit [39:0] ppr;
        bit [13:0] tf;
        bit [31:0] pk;
        bit [31:0] oc;
        bit [31:0] fi;
        bit [31:0] la;
        int        order;
        bit        last_run;
    } t_flow_rec;

    class t_flow_scoreboard;
        bit [15:0] inact_s = nfc_pkg::INACT_S_RST;
        bit [15:0] act_s = nfc_pkg::ACT_S_RST;
        bit [5:0]  limit_reg = nfc_pkg::LIMIT_RST;
        bit        started;
        bit [31:0] start_s;
        bit [19:0] start_us;
        bit        used[SLOTS];
        bit [63:0] addr[SLOTS];
        bit [39:0] ppr[SLOTS];
        bit [13:0] tf[SLOTS];
        bit [31:0] pk[SLOTS];
        bit [31:0] oc[SLOTS];
        bit [31:0] fi[SLOTS];
        bit [31:0] la[SLOTS];
        t_flow_rec exported[$];
        t_flow_rec expected_flows[$];
        int errors;

        function void write_reg(bit [1:0] idx, bit [15:0] data);
            case (idx)
                nfc_pkg::CFG_INACTIVE: inact_s = data;
                nfc_pkg::CFG_ACTIVE: act_s = data;
                nfc_pkg::CFG_LIMIT: limit_reg = data[5:0];
                default: ;
            endcase
        endfunction

        function bit [31:0] uptime(bit [31:0] s, bit [19:0] us);
            bit [31:0] ds;
            int du;
            ds = s - start_s;
            du = int'(us) - int'(start_us);
            if (du < 0) begin
                du += nfc_pkg::US_PER_S;
                ds -= 1;
            end
            return ds * 32'd1000 + 32'(du / nfc_pkg::MS_PER_S);
        endfunction

        function void evict(int i);
            t_flow_rec r;
            r.addr = addr[i];
            r.ppr = ppr[i];
            r.tf = tf[i];
            r.pk = pk[i];
            r.oc = oc[i];
            r.fi = fi[i];
            r.la = la[i];
            r.order = exported.size();
            r.last_run = 0;
            exported.insert(exported.size(), r);
            used[i] = 0;
        endfunction

        function bit older(bit [31:0] fa, bit [63:0] aa, bit [39:0] pa,
                           bit [31:0] fb, bit [63:0] ab, bit [39:0] pb);
            if (fa != fb) return fa < fb;
            if (aa != ab) return aa < ab;
            return pa < pb;
        endfunction

        function void timeout_pass(bit [31:0] now);
            bit [31:0] inact;
            bit [31:0] act;
            inact = inact_s * 32'd1000;
            act = act_s * 32'd1000;
            for (int i = 0; i < SLOTS; i++)
                if (used[i] && ((now - la[i]) > inact || (la[i] - fi[i]) > act ||
                                (tf[i] & 14'h5) != 0))
                    evict(i);
        endfunction

        function void note_packet(t_packet p);
            bit [63:0] a;
            bit [39:0] q;
            bit [19:0] us;
            bit [31:0] now;
            int hit;
            int lim;
            int cnt;
            int old;
            int slot;
            t_flow_rec t;
            int j;
            a = {p.sa, p.da};
            q = {p.sp, p.dp, p.proto};
            us = (p.tus > nfc_pkg::US_MAX) ? 20'(nfc_pkg::US_MAX) : p.tus;
            if (!started) begin
                start_s = p.ts;
                start_us = us;
                started = 1;
            end
            exported.delete();
            now = uptime(p.ts, us);
            timeout_pass(now);
            hit = -1;
            for (int i = 0; i < SLOTS; i++)
                if (used[i] && addr[i] == a && ppr[i] == q) hit = i;
            if (hit >= 0) begin
                la[hit] = now;
                pk[hit] += 1;
                oc[hit] += p.len;
                tf[hit] |= p.flags;
            end else begin
                lim = (limit_reg == 0) ? 1 : (limit_reg > SLOTS) ? SLOTS : limit_reg;
                forever begin
                    old = -1;
                    cnt = 0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!used[i]) continue;
                        cnt++;
                        if (old < 0 || older(fi[i], addr[i], ppr[i], fi[old], addr[old],
                                             ppr[old]))
                            old = i;
                    end
                    if (cnt < lim || old < 0) break;
                    evict(old);
                end
                slot = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!used[i]) slot = i;
                if (slot >= 0) begin
                    used[slot] = 1;
                    addr[slot] = a;
                    ppr[slot] = q;
                    tf[slot] = {p.tos, p.flags};
                    pk[slot] = 1;
                    oc[slot] = p.len;
                    fi[slot] = now;
                    la[slot] = now;
                end
            end
            timeout_pass(now);
            for (int k = 1; k < exported.size(); k++) begin
                t = exported[k];
                j = k;
                while (j > 0 && older(t.fi, t.addr, t.ppr, exported[j-1].fi,
                                      exported[j-1].addr, exported[j-1].ppr)) begin
                    exported[j] = exported[j-1];
                    j--;
                end
                exported[j] = t;
            end
            foreach (exported[k]) begin
                exported[k].last_run = (k == exported.size() - 1);
                expected_flows.insert(expected_flows.size(), exported[k]);
            end
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_flow(t_flow_rec got);
            t_flow_rec w;
            if (expected_flows.size() == 0) begin
                report("unexpected record", got.addr, 0);
                return;
            end
            w = expected_flows.pop_front();
            if (got.addr[63:32] != w.addr[63:32])
                report("source address", got.addr[63:32], w.addr[63:32]);
            if (got.addr[31:0] != w.addr[31:0])
                report("destination address", got.addr[31:0], w.addr[31:0]);
            if (got.ppr[39:24] != w.ppr[39:24])
                report("source port", got.ppr[39:24], w.ppr[39:24]);
            if (got.ppr[23:8] != w.ppr[23:8])
                report("destination port", got.ppr[23:8], w.ppr[23:8]);
            if (got.ppr[7:0] != w.ppr[7:0]) report("protocol", got.ppr[7:0], w.ppr[7:0]);
            if (got.tf[13:6] != w.tf[13:6]) report("tos", got.tf[13:6], w.tf[13:6]);
            if (got.tf[5:0] != w.tf[5:0]) report("tcp flags", got.tf[5:0], w.tf[5:0]);
            if (got.pk != w.pk) report("packet count", got.pk, w.pk);
            if (got.oc != w.oc) report("octet count", got.oc, w.oc);
            if (got.fi != w.fi) report("first ms", got.fi, w.fi);
            if (got.la != w.la) report("last ms", got.la, w.la);
            if (got.last_run != w.last_run) report("last of run", got.last_run, w.last_run);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [31:0] i_source_address = 0;
    logic [31:0] i_destination_address = 0;
    logic [15:0] i_source_port = 0;
    logic [15:0] i_destination_port = 0;
    logic [7:0]  i_protocol = 0;
    logic [7:0]  i_type_of_service = 0;
    logic [5:0]  i_tcp_flags = 0;
    logic [15:0] i_byte_length = 0;
    logic [31:0] i_time_seconds = 0;
    logic [19:0] i_time_microseconds = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [31:0] o_out_source_address;
    logic [31:0] o_out_destination_address;
    logic [15:0] o_out_source_port;
    logic [15:0] o_out_destination_port;
    logic [7:0]  o_out_protocol;
    logic [7:0]  o_out_type_of_service;
    logic [5:0]  o_out_tcp_flags;
    logic [31:0] o_packet_count;
    logic [31:0] o_octet_count;
    logic [31:0] o_first_ms;
    logic [31:0] o_last_ms;
    logic        o_last_of_run;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 0;
    logic [15:0] i_cfg_data = 0;

    netflow_flow_cache_unit dut (.*);

    t_flow_scoreboard flows = new();
    int cycles;
    int stall;
    bit calm;
    bit [31:0] clock_s;
    t_packet key_pool[40];

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        t_flow_rec got;
        if (i_rst_n && o_valid && i_ready) begin
            got.addr = {o_out_source_address, o_out_destination_address};
            got.ppr = {o_out_source_port, o_out_destination_port, o_out_protocol};
            got.tf = {o_out_type_of_service, o_out_tcp_flags};
            got.pk = o_packet_count;
            got.oc = o_octet_count;
            got.fi = o_first_ms;
            got.la = o_last_ms;
            got.last_run = o_last_of_run;
            flows.check_flow(got);
        end
        if (!i_rst_n) begin
            i_ready <= 0;
        end else if (stall > 0) begin
            stall <= stall - 1;
            i_ready <= 0;
        end else begin
            i_ready <= 1;
            if (o_valid && i_ready) stall <= pick_gap();
        end
    end

    task send_packet(t_packet p);
        int g;
        g = pick_gap();
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1;
        i_source_address <= p.sa;
        i_destination_address <= p.da;
        i_source_port <= p.sp;
        i_destination_port <= p.dp;
        i_protocol <= p.proto;
        i_type_of_service <= p.tos;
        i_tcp_flags <= p.flags;
        i_byte_length <= p.len;
        i_time_seconds <= p.ts;
        i_time_microseconds <= p.tus;
        do @(posedge i_clk); while (!o_ready);
        flows.note_packet(p);
    endtask

    task settle();
        i_valid <= 0;
        while (flows.expected_flows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(bit [1:0] idx, bit [15:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        flows.write_reg(idx, data);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task configure(bit [15:0] inact, bit [15:0] act, bit [15:0] lim);
        settle();
        write_reg(nfc_pkg::CFG_INACTIVE, inact);
        write_reg(nfc_pkg::CFG_ACTIVE, act);
        write_reg(nfc_pkg::CFG_LIMIT, lim);
    endtask

    function t_packet random_packet(int fresh_pct);
        t_packet p;
        int r;
        if ($urandom_range(0, 99) < fresh_pct) begin
            p.sa = $urandom;
            p.da = $urandom;
            p.sp = $urandom;
            p.dp = $urandom;
            p.proto = $urandom;
        end else begin
            p = key_pool[$urandom_range(0, 39)];
        end
        p.tos = $urandom;
        p.flags = $urandom;
        if ($urandom_range(0, 99) < 85) p.flags[2] = 0;
        if ($urandom_range(0, 99) < 85) p.flags[0] = 0;
        p.len = $urandom;
        r = $urandom_range(0, 99);
        if (r < 60) clock_s += $urandom_range(0, 1);
        else if (r < 95) clock_s += $urandom_range(2, 8);
        else clock_s += $urandom_range(50, 200);
        p.ts = ($urandom_range(0, 99) < 3) ? clock_s - $urandom_range(1, 100) : clock_s;
        p.tus = ($urandom_range(0, 99) < 5)
              ? 20'($urandom_range(nfc_pkg::US_PER_S, 20'hFFFFF))
              : 20'($urandom_range(0, nfc_pkg::US_MAX));
        return p;
    endfunction

    task random_phase(int n);
        for (int k = 0; k < n; k++) begin
            if (k % 25 == 0) calm = ($urandom_range(0, 3) == 0);
            send_packet(random_packet(15));
        end
        calm = 0;
    endtask

    initial begin
        t_packet p;
        foreach (key_pool[i]) begin
            key_pool[i].sa = $urandom;
            key_pool[i].da = $urandom;
            key_pool[i].sp = $urandom;
            key_pool[i].dp = $urandom;
            key_pool[i].proto = $urandom;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        clock_s = 32'h1000;
        p = '{32'h0A000001, 32'h0A000002, 16'd1234, 16'd80, 8'd6, 8'h10, 6'h02,
              16'd60, 32'h1000, 20'd500000};
        send_packet(p);
        p.flags = 6'h10;
        p.ts = 32'h1001;
        send_packet(p);
        p.tus = 20'hFFFFF;
        p.len = 16'hFFFF;
        send_packet(p);
        p.ts = 32'h0FFF;
        send_packet(p);
        p.flags = 6'h01;
        p.ts = 32'h1002;
        send_packet(p);
        send_packet('{32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 6'h3F,
                      16'hFFFF, 32'h1002, 20'd999999});
        send_packet('{32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 8'h0, 6'h00, 16'h0, 32'h1003,
                      20'd0});
        send_packet('{32'h0, 32'h0, 16'h0, 16'h0, 8'h0, 8'h0, 6'h04, 16'h1, 32'h1003,
                      20'd1});
        send_packet('{32'h1, 32'h2, 16'h0, 16'h0800, 8'd1, 8'h0, 6'h00, 16'd84,
                      32'h1003, 20'd2000});
        send_packet('{32'h1, 32'h2, 16'h0, 16'h0800, 8'd1, 8'h0, 6'h00, 16'd84,
                      32'h1020, 20'd0});
        clock_s = 32'h1020;
        configure(16'd1, 16'd2, 16'd2);
        write_reg(CFG_UNUSED, 16'hFFFF);
        for (int k = 0; k < 6; k++) begin
            p = random_packet(100);
            p.flags = 0;
            p.ts = clock_s;
            send_packet(p);
        end
        configure(16'd0, 16'd0, 16'd0);
        for (int k = 0; k < 4; k++) send_packet(random_packet(50));

        configure(nfc_pkg::INACT_S_RST, nfc_pkg::ACT_S_RST, 16'(nfc_pkg::LIMIT_RST));
        random_phase(80);
        configure(16'd3, 16'd6, 16'd4);
        random_phase(70);
        configure(16'hFFFF, 16'hFFFF, 16'd63);
        random_phase(80);
        configure(16'd2, 16'd5, 16'd12);
        random_phase(70);
        configure(16'd0, 16'd1, 16'd1);
        random_phase(60);
        configure(16'd20, 16'd30, 16'd32);
        random_phase(100);

        settle();
        if (flows.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/nfc_pkg.sv
hw/rtl/nfc_cell.sv
hw/rtl/nfc_uptime.sv
hw/rtl/netflow_flow_cache_unit.sv
tb/sv/tb_netflow_flow_cache_unit.sv
